// File: rtl/aescfb8_pkg.sv
// shared constants, types and byte functions for the aes-128 cfb8 cipher
package aescfb8_pkg;

    localparam int BLOCK_W   = 128;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int ROUNDS    = 10;
    localparam int RND_W     = 4;

    typedef logic [7:0]         byte_t;
    typedef logic [BLOCK_W-1:0] block_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 3'd0,
        REG_KEY_LOW  = 3'd1,
        REG_IV_HIGH  = 3'd2,
        REG_IV_LOW   = 3'd3,
        REG_DECRYPT  = 3'd4
    } cfg_reg_t;

    localparam byte_t RCON_FIRST = 8'h01;
    localparam byte_t POLY_RED   = 8'h1b;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic byte_t sub_byte(input byte_t v);
        return SBOX[v];
    endfunction

    // multiply by two in the aes field
    function automatic byte_t xtime(input byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? POLY_RED : 8'h00);
    endfunction

endpackage

// File: rtl/aescfb8_if.sv
// handshake channel interfaces for the input and result beats
interface aescfb8_in_if;
    logic                valid;
    logic                ready;
    aescfb8_pkg::byte_t  in_byte;
    logic                message_start;

    modport source (output valid, output in_byte, output message_start, input ready);
    modport sink   (input valid, input in_byte, input message_start, output ready);
endinterface

interface aescfb8_out_if;
    logic                valid;
    logic                ready;
    aescfb8_pkg::byte_t  out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// File: rtl/aes128_cfb8_cipher.sv
// aes-128 cfb8 byte cipher: configuration, sequencer and feedback register
//
// Usage: write key_high, key_low, iv_high, iv_low and decrypt_mode through
// the write port (cfg_we, cfg_index, cfg_data) while no byte is in flight.
// Bytes enter on in_ch (in_byte, message_start) and results leave on out_ch
// (out_byte), both valid/ready channels; one result beat per input beat.
// A beat with message_start loads the feedback register from the iv first.
// Each byte runs one full encryption of the feedback register through a
// single shared round unit, one round per cycle, with round keys derived
// on the fly alongside. The initial key addition is done as the beat is
// taken; the result is registered when the tenth round ends, and no new
// beat is taken until the sequencer is back in idle.
// in_ch.ready is high only while the sequencer is idle. If the receiver
// stalls, the result waits in the output register; a further finished
// byte then holds in the sequencer until the output register frees.
// Reset clears the key, iv, mode and feedback register to zero.
module aes128_cfb8_cipher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    aescfb8_in_if.sink                           in_ch,
    aescfb8_out_if.source                        out_ch,
    input  logic                                 cfg_we,
    input  logic [aescfb8_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aescfb8_pkg::CFG_W-1:0]        cfg_data
);
    import aescfb8_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_HOLD  = 3'b100
    } seq_state_t;

    seq_state_t         seq_reg, seq_next;
    logic [CFG_W-1:0]   key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic               decrypt_reg;
    block_t             fb_reg, fb_next;
    block_t             blk_reg, blk_next;
    block_t             rk_reg, rk_next;
    byte_t              rcon_reg, rcon_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    byte_t              din_reg, din_next;
    byte_t              res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    byte_t              out_byte_reg, out_byte_next;

    block_t             key_full, base, rnd_state, rnd_key;
    logic               last_round, accept, slot_free;
    byte_t              res_now, fed_now;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            decrypt_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                REG_IV_LOW:   iv_low_reg   <= cfg_data;
                REG_DECRYPT:  decrypt_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign key_full   = {key_high_reg, key_low_reg};
    assign base       = in_ch.message_start ? {iv_high_reg, iv_low_reg} : fb_reg;
    assign last_round = (rnd_reg == RND_W'(ROUNDS));
    assign accept     = in_ch.valid && in_ch.ready;
    assign slot_free  = !out_valid_reg || out_ch.ready;

    assign in_ch.ready     = (seq_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;

    // shared round unit
    aescfb8_round u_round (
        .state_in   (blk_reg),
        .rkey_in    (rk_reg),
        .rcon       (rcon_reg),
        .last_round (last_round),
        .state_out  (rnd_state),
        .rkey_out   (rnd_key)
    );

    assign res_now = din_reg ^ rnd_state[BLOCK_W-1 -: 8];
    assign fed_now = decrypt_reg ? din_reg : res_now;

    // sequencer
    always_comb
    begin
        seq_next       = seq_reg;
        fb_next        = fb_reg;
        blk_next       = blk_reg;
        rk_next        = rk_reg;
        rcon_next      = rcon_reg;
        rnd_next       = rnd_reg;
        din_next       = din_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        case (seq_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fb_next   = base;
                    blk_next  = base ^ key_full;
                    rk_next   = key_full;
                    rcon_next = RCON_FIRST;
                    rnd_next  = RND_W'(1);
                    din_next  = in_ch.in_byte;
                    seq_next  = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                blk_next  = rnd_state;
                rk_next   = rnd_key;
                rcon_next = xtime(rcon_reg);
                rnd_next  = rnd_reg + RND_W'(1);
                if (last_round)
                begin
                    fb_next  = {fb_reg[BLOCK_W-9:0], fed_now};
                    res_next = res_now;
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = res_now;
                        seq_next       = ST_IDLE;
                    end
                    else
                    begin
                        seq_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_reg;
                    seq_next       = ST_IDLE;
                end
            end
            default:
            begin
                seq_next = ST_IDLE;
            end
        endcase
    end

    // control and feedback state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ST_IDLE;
            fb_reg        <= '0;
            out_valid_reg <= 1'b0;
            rnd_reg       <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            fb_reg        <= fb_next;
            out_valid_reg <= out_valid_next;
            rnd_reg       <= rnd_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        rk_reg       <= rk_next;
        rcon_reg     <= rcon_next;
        din_reg      <= din_next;
        res_reg      <= res_next;
        out_byte_reg <= out_byte_next;
    end

    // a taken beat starts the first round
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (seq_reg == ST_ROUND) && (rnd_reg == RND_W'(1)))
        else $error("round sequence did not start after an input beat");

    // the tenth round always leaves the round state
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == ST_ROUND) && last_round |=> (seq_reg != ST_ROUND))
        else $error("round sequence ran past the final round");

    // holding a result means the output register is occupied
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == ST_HOLD) |-> out_valid_reg)
        else $error("result held while output register is empty");

    // a result beat is only raised by finishing a byte
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(seq_reg) == ST_ROUND) || ($past(seq_reg) == ST_HOLD))
        else $error("result beat appeared without a finished byte");

endmodule

// File: rtl/aescfb8_round.sv
// one aes-128 round with the matching key schedule step
module aescfb8_round (
    input  aescfb8_pkg::block_t state_in,
    input  aescfb8_pkg::block_t rkey_in,
    input  aescfb8_pkg::byte_t  rcon,
    input  logic                last_round,
    output aescfb8_pkg::block_t state_out,
    output aescfb8_pkg::block_t rkey_out
);
    import aescfb8_pkg::*;

    byte_t st [16];
    byte_t sb [16];
    byte_t mc [16];
    byte_t kb [16];
    byte_t nk [16];
    byte_t tw [4];

    // split into bytes, byte 0 in the top bits
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            st[i] = state_in[BLOCK_W-1-8*i -: 8];
            kb[i] = rkey_in[BLOCK_W-1-8*i -: 8];
        end
    end

    // next round key
    always_comb
    begin
        tw[0] = sub_byte(kb[13]) ^ rcon;
        tw[1] = sub_byte(kb[14]);
        tw[2] = sub_byte(kb[15]);
        tw[3] = sub_byte(kb[12]);
        for (int k = 0; k < 4; k++)
        begin
            nk[k]      = kb[k] ^ tw[k];
            nk[k + 4]  = kb[k + 4] ^ nk[k];
            nk[k + 8]  = kb[k + 8] ^ nk[k + 4];
            nk[k + 12] = kb[k + 12] ^ nk[k + 8];
        end
    end

    // substitution and row rotation
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[r + 4*c] = sub_byte(st[r + 4*((c + r) % 4)]);
            end
        end
    end

    // column mixing, skipped in the final round
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            byte_t a0, a1, a2, a3, s;
            a0 = sb[4*c];
            a1 = sb[4*c + 1];
            a2 = sb[4*c + 2];
            a3 = sb[4*c + 3];
            s  = a0 ^ a1 ^ a2 ^ a3;
            if (last_round)
            begin
                mc[4*c]     = a0;
                mc[4*c + 1] = a1;
                mc[4*c + 2] = a2;
                mc[4*c + 3] = a3;
            end
            else
            begin
                mc[4*c]     = a0 ^ s ^ xtime(a0 ^ a1);
                mc[4*c + 1] = a1 ^ s ^ xtime(a1 ^ a2);
                mc[4*c + 2] = a2 ^ s ^ xtime(a2 ^ a3);
                mc[4*c + 3] = a3 ^ s ^ xtime(a3 ^ a0);
            end
        end
    end

    // add round key and repack
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            state_out[BLOCK_W-1-8*i -: 8] = mc[i] ^ nk[i];
            rkey_out[BLOCK_W-1-8*i -: 8]  = nk[i];
        end
    end

endmodule

// File: verif/aes128_cfb8_cipher_tb.sv
// testbench for the aes-128 cfb8 byte cipher: predictor, driver and monitor
module aes128_cfb8_cipher_tb;
    import aescfb8_pkg::*;

    typedef struct packed {
        byte_t in_byte;
        logic  message_start;
    } beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    aescfb8_in_if  in_ch ();
    aescfb8_out_if out_ch ();

    aes128_cfb8_cipher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [63:0] key_hi_m, key_lo_m, iv_hi_m, iv_lo_m;
    logic        decrypt_m;
    byte_t       shift_reg [16];
    byte_t       round_keys [176];

    beat_t pending_beats [$];
    byte_t expected_bytes [$];
    int    errors;
    bit    stim_done;

    // key schedule from the current key registers
    function automatic void expand_round_keys();
        byte_t w [4];
        byte_t lead;
        byte_t rc;
        rc = 8'h01;
        for (int n = 0; n < 8; n++)
        begin
            round_keys[n]     = key_hi_m[63-8*n -: 8];
            round_keys[n + 8] = key_lo_m[63-8*n -: 8];
        end
        for (int p = 16; p < 176; p += 4)
        begin
            for (int k = 0; k < 4; k++)
                w[k] = round_keys[p - 4 + k];
            if (p % 16 == 0)
            begin
                lead = w[0];
                w[0] = SBOX[w[1]] ^ rc;
                w[1] = SBOX[w[2]];
                w[2] = SBOX[w[3]];
                w[3] = SBOX[lead];
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            for (int k = 0; k < 4; k++)
                round_keys[p + k] = round_keys[p - 16 + k] ^ w[k];
        end
    endfunction

    function automatic byte_t dbl(byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // first keystream byte: full encryption of the shift register
    function automatic byte_t keystream_byte();
        byte_t st [16];
        byte_t tmp [16];
        byte_t a0, a1, a2, a3, s;
        for (int i = 0; i < 16; i++)
            st[i] = shift_reg[i] ^ round_keys[i];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    tmp[i + 4*c] = SBOX[st[i + 4*((c + i) % 4)]];
            if (r != 10)
            begin
                for (int c = 0; c < 16; c += 4)
                begin
                    a0 = tmp[c]; a1 = tmp[c+1]; a2 = tmp[c+2]; a3 = tmp[c+3];
                    s = a0 ^ a1 ^ a2 ^ a3;
                    tmp[c]   = a0 ^ s ^ dbl(a0 ^ a1);
                    tmp[c+1] = a1 ^ s ^ dbl(a1 ^ a2);
                    tmp[c+2] = a2 ^ s ^ dbl(a2 ^ a3);
                    tmp[c+3] = a3 ^ s ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = tmp[i] ^ round_keys[16*r + i];
        end
        return st[0];
    endfunction

    function automatic byte_t cipher_byte(beat_t b);
        byte_t res;
        if (b.message_start)
            for (int n = 0; n < 8; n++)
            begin
                shift_reg[n]     = iv_hi_m[63-8*n -: 8];
                shift_reg[n + 8] = iv_lo_m[63-8*n -: 8];
            end
        res = b.in_byte ^ keystream_byte();
        for (int i = 0; i < 15; i++)
            shift_reg[i] = shift_reg[i + 1];
        shift_reg[15] = decrypt_m ? b.in_byte : res;
        return res;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    int src_gap;
    initial src_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.in_byte <= '0;
            in_ch.message_start <= 1'b0;
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
            // hold the beat
        end
        else if (src_gap > 0)
        begin
            src_gap <= src_gap - 1;
            in_ch.valid <= 1'b0;
        end
        else if (pending_beats.size() > 0)
        begin
            in_ch.valid <= 1'b1;
            in_ch.in_byte <= pending_beats[0].in_byte;
            in_ch.message_start <= pending_beats[0].message_start;
            expected_bytes.push_back(cipher_byte(pending_beats[0]));
            void'(pending_beats.pop_front());
            src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end
        else
            in_ch.valid <= 1'b0;
    end

    // monitor with random receiver stalls
    int sink_gap;
    byte_t exp_b;
    initial sink_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual out_byte %02h", $time,
                             out_ch.out_byte);
                    errors++;
                end
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    if (out_ch.out_byte !== exp_b)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h", $time,
                                 exp_b, out_ch.out_byte);
                        errors++;
                    end
                end
                sink_gap <= (stim_done || $urandom_range(0, 3) == 0) ? 0
                                                                   : $urandom_range(0, 9);
                out_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY_HIGH: begin key_hi_m = value; expand_round_keys(); end
            REG_KEY_LOW:  begin key_lo_m = value; expand_round_keys(); end
            REG_IV_HIGH:  iv_hi_m = value;
            REG_IV_LOW:   iv_lo_m = value;
            REG_DECRYPT:  decrypt_m = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_ch.valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_message(int len, bit restart);
        beat_t b;
        for (int i = 0; i < len; i++)
        begin
            b.in_byte = byte_t'($urandom_range(0, 255));
            b.message_start = (i == 0) ? restart : ($urandom_range(0, 29) == 0);
            pending_beats.push_back(b);
        end
    endtask

    // stimulus
    beat_t db;
    initial
    begin
        errors = 0;
        stim_done = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        key_hi_m = '0; key_lo_m = '0; iv_hi_m = '0; iv_lo_m = '0;
        decrypt_m = 1'b0;
        for (int i = 0; i < 16; i++)
            shift_reg[i] = '0;
        expand_round_keys();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset key and zero register, no restart first
        db = '{in_byte: 8'h00, message_start: 1'b0}; pending_beats.push_back(db);
        db = '{in_byte: 8'hff, message_start: 1'b0}; pending_beats.push_back(db);
        db = '{in_byte: 8'h80, message_start: 1'b1}; pending_beats.push_back(db);
        wait_drained();
        // all-ones key and iv, encrypt then decrypt
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_IV_HIGH, '1);
        write_reg(REG_IV_LOW, '1);
        db = '{in_byte: 8'h01, message_start: 1'b1}; pending_beats.push_back(db);
        db = '{in_byte: 8'hfe, message_start: 1'b0}; pending_beats.push_back(db);
        db = '{in_byte: 8'h7f, message_start: 1'b0}; pending_beats.push_back(db);
        wait_drained();
        write_reg(REG_DECRYPT, 1'b1);
        db = '{in_byte: 8'h55, message_start: 1'b1}; pending_beats.push_back(db);
        db = '{in_byte: 8'haa, message_start: 1'b0}; pending_beats.push_back(db);
        db = '{in_byte: 8'hff, message_start: 1'b0}; pending_beats.push_back(db);
        wait_drained();
        // key change without restart keeps the feedback bytes
        write_reg(REG_KEY_LOW, 64'h0123456789abcdef);
        db = '{in_byte: 8'h00, message_start: 1'b0}; pending_beats.push_back(db);
        db = '{in_byte: 8'h3c, message_start: 1'b0}; pending_beats.push_back(db);
        wait_drained();
        // iv write takes effect only at the next restart
        write_reg(REG_IV_HIGH, 64'h0);
        db = '{in_byte: 8'h12, message_start: 1'b0}; pending_beats.push_back(db);
        db = '{in_byte: 8'h34, message_start: 1'b1}; pending_beats.push_back(db);
        wait_drained();

        // random phases: new settings, then messages
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(REG_KEY_HIGH, (ph == 9) ? 64'h0 : rand64());
            write_reg(REG_KEY_LOW, (ph == 9) ? 64'h0 : rand64());
            write_reg(REG_IV_HIGH, rand64());
            write_reg(REG_IV_LOW, (ph == 8) ? 64'h0 : rand64());
            write_reg(REG_DECRYPT, ph[0]);
            for (int m = 0; m < 3; m++)
                queue_message($urandom_range(4, 30), $urandom_range(0, 5) != 0);
            wait_drained();
        end
        stim_done = 1;
        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // overall time limit
    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
